// File: sv/pip_pkg.sv
// Package for the point-in-polygon ray cast block.
// Holds the controller/datapath command and status structs and the op codes.
// No dependencies.
`timescale 1ns / 1ps

package pip_pkg;

   // Width of the distance field on the result channel
   localparam int DIST_OUT_BITS = 33;

   // Input op codes
   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_VERTEX = 1'b1;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load_point;   // store test point, clear area state
      logic take_vertex;  // register segment ends, update previous vertex
      logic setup;        // differences and magnitudes
      logic mul_lo;       // low partial product
      logic mul_hi;       // high partial product, accumulate
      logic div_step;     // one restoring division step
      logic finish;       // crossing x
      logic update;       // parity and nearest distance
      logic emit;         // load result register, clear area state
   } dp_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic have_prev;    // a previous vertex of the current line exists
      logic skip;         // segment misses the ray (valid in setup)
   } dp_stat_type;

endpackage

// File: sv/pip_datapath.sv
// Datapath of the point-in-polygon block: point and area state, segment
// registers, shared half-width multiplier, restoring divider, result register.
// Depends on pip_pkg.
`timescale 1ns / 1ps

module pip_datapath #(
   parameter int COORD_BITS = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  pip_pkg::dp_cmd_type                   cmd,
   output pip_pkg::dp_stat_type                  stat,
   input  logic signed [COORD_BITS-1:0]          in_x,
   input  logic signed [COORD_BITS-1:0]          in_y,
   output logic                                  rsp_inside_res,
   output logic [pip_pkg::DIST_OUT_BITS-1:0]     rsp_distance
);

   localparam int CW    = COORD_BITS;
   localparam int YW    = CW + 1;          // adjusted y
   localparam int AW    = CW + 1;          // magnitudes and quotient
   localparam int PW    = 2 * AW;          // product
   localparam int HW    = (AW + 1) / 2;    // multiplier operand slice
   localparam int XW    = CW + 2;          // crossing x
   localparam int DW    = CW + 1;          // nearest distance
   localparam int EXT_W = (DW > pip_pkg::DIST_OUT_BITS) ? DW : pip_pkg::DIST_OUT_BITS;

   // Point and area state
   logic signed [CW-1:0] test_x_ff, test_y_ff, prev_x_ff, prev_y_ff;
   logic                 have_prev_ff, odd_ff;
   logic [DW-1:0]        nearest_ff;

   // Segment registers
   logic signed [CW-1:0] bx_ff, ex_ff;
   logic signed [YW-1:0] by_ff, ey_ff;
   logic [AW-1:0]        ax_ff, at_ff, ad_ff;
   logic                 neg_ff;
   logic [PW-1:0]        prod_ff;
   logic signed [XW-1:0] xi_ff;

   // Result register
   logic                             inside_ff;
   logic [pip_pkg::DIST_OUT_BITS-1:0] dist_out_ff;

   // Move a vertex on the ray one step away from zero; a vertex at zero stays
   function automatic logic signed [YW-1:0] adj_y(input logic signed [CW-1:0] y,
                                                   input logic signed [CW-1:0] ty);
      logic signed [YW-1:0] ye, tye;
      ye  = {y[CW-1], y};
      tye = {ty[CW-1], ty};
      if (y != ty) return ye;
      else if (ty > 0) return tye + YW'(1);
      else if (ty < 0) return tye - YW'(1);
      else return tye;
   endfunction

   // Setup: skip test and magnitudes
   logic signed [YW-1:0] tx_e, ty_e, bx_e, ex_e, dx;
   logic signed [YW:0]   t_w, d_w;
   logic [YW-1:0]        dx_mag;
   logic [YW:0]          t_mag, d_mag;
   logic                 skip;

   always_comb begin
      tx_e   = {test_x_ff[CW-1], test_x_ff};
      ty_e   = {test_y_ff[CW-1], test_y_ff};
      bx_e   = {bx_ff[CW-1], bx_ff};
      ex_e   = {ex_ff[CW-1], ex_ff};
      skip   = (by_ff < ty_e && ey_ff < ty_e) || (by_ff > ty_e && ey_ff > ty_e) ||
               (bx_e < tx_e && ex_e < tx_e) || (by_ff == ty_e && ey_ff == ty_e) ||
               (ey_ff == by_ff);
      dx     = ex_e - bx_e;
      t_w    = {ty_e[YW-1], ty_e} - {by_ff[YW-1], by_ff};
      d_w    = {ey_ff[YW-1], ey_ff} - {by_ff[YW-1], by_ff};
      dx_mag = dx[YW-1] ? -dx : dx;
      t_mag  = t_w[YW] ? -t_w : t_w;
      d_mag  = d_w[YW] ? -d_w : d_w;
   end

   // Shared multiplier: ax times one slice of at
   logic [HW-1:0]    mul_b;
   logic [AW+HW-1:0] mul_p;
   assign mul_b = cmd.mul_lo ? at_ff[HW-1:0] : HW'(at_ff[AW-1:HW]);
   assign mul_p = (AW+HW)'(ax_ff) * (AW+HW)'(mul_b);

   // Restoring division step: remainder in the upper half, quotient shifts in below
   logic [AW-1:0] rem;
   logic [AW+1:0] trial;
   assign rem   = prod_ff[PW-1:AW];
   assign trial = {1'b0, rem, prod_ff[AW-1]} - {2'b00, ad_ff};

   // Crossing x from clamped quotient
   logic [AW-1:0]        q_c;
   logic signed [XW-1:0] bx_x, q_x, xi_in;
   always_comb begin
      q_c   = (prod_ff[AW-1:0] > ax_ff) ? ax_ff : prod_ff[AW-1:0];
      bx_x  = {{2{bx_ff[CW-1]}}, bx_ff};
      q_x   = {1'b0, q_c};
      xi_in = neg_ff ? (bx_x - q_x) : (bx_x + q_x);
   end

   // Update: distance to test x
   logic signed [XW-1:0] tx_x, diff;
   logic [DW-1:0]        cross_dist;
   logic                 right_of;
   logic [EXT_W-1:0]     nearest_ext;
   always_comb begin
      tx_x        = {{2{test_x_ff[CW-1]}}, test_x_ff};
      diff        = xi_ff - tx_x;
      cross_dist  = diff[DW-1:0];
      right_of    = xi_ff > tx_x;
      nearest_ext = EXT_W'(nearest_ff);
   end

   // Point and area state
   always_ff @(posedge clock) begin
      if (reset) begin
         test_x_ff    <= '0;
         test_y_ff    <= '0;
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         have_prev_ff <= 1'b0;
         odd_ff       <= 1'b0;
         nearest_ff   <= '1;
      end else begin
         if (cmd.load_point) begin
            test_x_ff    <= in_x;
            test_y_ff    <= in_y;
            have_prev_ff <= 1'b0;
            odd_ff       <= 1'b0;
            nearest_ff   <= '1;
         end
         if (cmd.take_vertex) begin
            prev_x_ff    <= in_x;
            prev_y_ff    <= in_y;
            have_prev_ff <= 1'b1;
         end
         if (cmd.update && right_of) begin
            odd_ff <= ~odd_ff;
            if (cross_dist < nearest_ff) nearest_ff <= cross_dist;
         end
         if (cmd.emit) begin
            have_prev_ff <= 1'b0;
            odd_ff       <= 1'b0;
            nearest_ff   <= '1;
         end
      end
   end

   // Segment arithmetic
   always_ff @(posedge clock) begin
      if (cmd.take_vertex) begin
         bx_ff <= prev_x_ff;
         by_ff <= adj_y(prev_y_ff, test_y_ff);
         ex_ff <= in_x;
         ey_ff <= adj_y(in_y, test_y_ff);
      end
      if (cmd.setup) begin
         ax_ff  <= dx_mag;
         at_ff  <= t_mag[AW-1:0];
         ad_ff  <= d_mag[AW-1:0];
         neg_ff <= dx[YW-1];
      end
      if (cmd.mul_lo) prod_ff <= PW'(mul_p);
      if (cmd.mul_hi) prod_ff <= prod_ff + (PW'(mul_p) << HW);
      if (cmd.div_step) begin
         if (!trial[AW+1]) prod_ff <= {trial[AW-1:0], prod_ff[AW-2:0], 1'b1};
         else prod_ff <= prod_ff << 1;
      end
      if (cmd.finish) xi_ff <= xi_in;
   end

   // Result register
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         inside_ff   <= odd_ff;
         dist_out_ff <= odd_ff ? nearest_ext[pip_pkg::DIST_OUT_BITS-1:0] : '0;
      end
   end

   assign stat.have_prev = have_prev_ff;
   assign stat.skip      = skip;
   assign rsp_inside_res = inside_ff;
   assign rsp_distance   = dist_out_ff;

endmodule

// File: sv/pip_ctrl.sv
// Controller of the point-in-polygon block: sequences setup, multiply, divide,
// finish and update for each segment reaching the ray and owns the result valid flag.
// Depends on pip_pkg.
`timescale 1ns / 1ps

module pip_ctrl #(
   parameter int COORD_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_op,
   input  logic                 req_line_start,
   input  logic                 req_area_end,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  pip_pkg::dp_stat_type stat,
   output pip_pkg::dp_cmd_type  cmd
);

   localparam int STEPS = COORD_BITS + 1;   // quotient bits
   localparam int CNT_W = $clog2(STEPS);

   typedef enum logic [2:0] {
      ST_IDLE, ST_SETUP, ST_MUL_LO, ST_MUL_HI, ST_DIV, ST_FINISH, ST_UPDATE, ST_DONE
   } state_type;

   state_type        state_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             last_ff, rsp_valid_ff;
   logic             accept, is_vertex, has_seg, out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign is_vertex = (req_op == pip_pkg::OP_VERTEX);
   assign has_seg   = stat.have_prev && !req_line_start;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // Datapath commands
   always_comb begin
      cmd             = '0;
      cmd.load_point  = accept && (req_op == pip_pkg::OP_LOAD);
      cmd.take_vertex = accept && is_vertex;
      cmd.setup       = (state_ff == ST_SETUP);
      cmd.mul_lo      = (state_ff == ST_MUL_LO);
      cmd.mul_hi      = (state_ff == ST_MUL_HI);
      cmd.div_step    = (state_ff == ST_DIV);
      cmd.finish      = (state_ff == ST_FINISH);
      cmd.update      = (state_ff == ST_UPDATE);
      cmd.emit        = (state_ff == ST_DONE) && out_free;
   end

   // State, step counter and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.emit) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;

         unique case (state_ff)
            ST_IDLE: begin
               if (accept && is_vertex) begin
                  last_ff <= req_area_end;
                  if (has_seg) state_ff <= ST_SETUP;
                  else if (req_area_end) state_ff <= ST_DONE;
               end
            end
            ST_SETUP: begin
               if (stat.skip) state_ff <= last_ff ? ST_DONE : ST_IDLE;
               else state_ff <= ST_MUL_LO;
            end
            ST_MUL_LO: state_ff <= ST_MUL_HI;
            ST_MUL_HI: begin
               cnt_ff   <= CNT_W'(STEPS - 1);
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               if (cnt_ff == '0) state_ff <= ST_FINISH;
               else cnt_ff <= cnt_ff - CNT_W'(1);
            end
            ST_FINISH: state_ff <= ST_UPDATE;
            ST_UPDATE: state_ff <= last_ff ? ST_DONE : ST_IDLE;
            ST_DONE:   if (out_free) state_ff <= ST_IDLE;
            default:   state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// File: sv/point_in_polygon_ray_cast.sv
// Top level of the point-in-polygon ray cast block.
// Joins pip_ctrl and pip_datapath; depends on pip_pkg.
//
//   channel | dir | handshake            | payload
//   req     | in  | req_valid/req_ready  | op, coord_x, coord_y, line_start, area_end
//   rsp     | out | rsp_valid/rsp_ready  | inside_res, distance
//
// A load beat, and a vertex beat without a segment, leave the block idle; such a
// vertex that ends the area passes through the done state. A vertex that closes a
// segment reaching the ray steps through setup, the low and high multiply, the
// one-bit-per-cycle restoring divider, finish and update (then done if it ends the
// area); a segment that misses the ray returns after setup (via done if it ends the
// area). Reset is synchronous and clears the point to 0. A result waits in the output
// register while the next beat is accepted; the block holds only when a further result must be written.
`timescale 1ns / 1ps

module point_in_polygon_ray_cast #(
   parameter int COORD_BITS = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_op,
   input  logic signed [COORD_BITS-1:0]          req_coord_x,
   input  logic signed [COORD_BITS-1:0]          req_coord_y,
   input  logic                                  req_line_start,
   input  logic                                  req_area_end,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_inside_res,
   output logic [pip_pkg::DIST_OUT_BITS-1:0]     rsp_distance
);

   pip_pkg::dp_cmd_type  cmd;
   pip_pkg::dp_stat_type stat;

   pip_ctrl #(.COORD_BITS(COORD_BITS)) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .req_line_start (req_line_start),
      .req_area_end   (req_area_end),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .stat           (stat),
      .cmd            (cmd)
   );

   pip_datapath #(.COORD_BITS(COORD_BITS)) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .in_x           (req_coord_x),
      .in_y           (req_coord_y),
      .rsp_inside_res (rsp_inside_res),
      .rsp_distance   (rsp_distance)
   );

   // A result is never written over one that has not been taken
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid || rsp_ready))
      else $error("result overwritten before its beat completed");

   // Outside results carry zero distance
   a_outside_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_inside_res) |-> (rsp_distance == '0))
      else $error("outside result with nonzero distance");

   // At most one sequenced datapath step per cycle
   a_one_step: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.setup, cmd.mul_lo, cmd.mul_hi, cmd.div_step,
                cmd.finish, cmd.update, cmd.emit, cmd.take_vertex}))
      else $error("overlapping datapath commands");

   // No beat is accepted while the division is running
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |=> !(req_valid && req_ready) || !cmd.div_step)
      else $error("beat accepted during division");

endmodule
